// File: src/mtcv_pkg.sv
package mtcv_pkg;

  // Stack depth default
  localparam int unsigned STACK_DEPTH_DEF = 8;

  localparam int unsigned NOTE_W = 8;
  localparam int unsigned PWM_W  = 10;

  // Channel 1 status bytes
  localparam logic [7:0] ST_NOTE_ON  = 8'h90;
  localparam logic [7:0] ST_NOTE_OFF = 8'h80;
  localparam logic [7:0] ST_PITCH    = 8'hE0;
  localparam logic [7:0] ST_CTRL     = 8'hB0;

  localparam logic [NOTE_W-1:0] NOTE_OFFSET = 8'd21;

  // Glide rate bands
  localparam logic [7:0] GLIDE_OFF_MAX = 8'd2;
  localparam logic [7:0] GLIDE_R1_LIM  = 8'd45;
  localparam logic [7:0] GLIDE_R2_MAX  = 8'd88;
  localparam logic [7:0] GLIDE_R1_SUB  = 8'd1;
  localparam logic [7:0] GLIDE_R2_SUB  = 8'd21;
  localparam logic [7:0] GLIDE_R3_SUB  = 8'd54;

  localparam logic [1:0] RANGE_OFF = 2'd0;
  localparam logic [1:0] RANGE_R1  = 2'd1;
  localparam logic [1:0] RANGE_R2  = 2'd2;
  localparam logic [1:0] RANGE_R3  = 2'd3;

  localparam logic [PWM_W-1:0] PWM_FULL    = 10'd1023;
  localparam logic [PWM_W-1:0] PITCH_RESET = 10'd511;
  localparam logic [1:0]       GLIDE_SEL_RESET = 2'd1;

  // Divider: fixed dividend over an 8-bit divisor
  localparam int unsigned DIVIDEND  = 1024;
  localparam int unsigned QUOT_W    = $clog2(DIVIDEND) + 1;
  localparam int unsigned DIVISOR_W = 8;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_NOTE_ON,
    CMD_NOTE_OFF,
    CMD_PITCH,
    CMD_CTRL
  } cmd_e;

  typedef enum logic [1:0] {
    T_IDLE,
    T_STACK,
    T_DIV,
    T_DONE
  } top_state_e;

  typedef enum logic {
    K_IDLE,
    K_SEARCH
  } stack_state_e;

  typedef enum logic {
    D_IDLE,
    D_RUN
  } div_state_e;

  typedef struct packed {
    logic              start;
    logic              pop;
    logic [NOTE_W-1:0] note;
  } stack_req_t;

  typedef struct packed {
    logic                 start;
    logic [DIVISOR_W-1:0] divisor;
  } div_req_t;

endpackage

// File: src/mtcv_div.sv
module mtcv_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  mtcv_pkg::div_req_t             req_i,
  output logic                           done_o,
  output logic [mtcv_pkg::QUOT_W-1:0]    quot_o
);
  import mtcv_pkg::*;

  localparam int unsigned StepW = $clog2(QUOT_W);
  localparam logic [QUOT_W-1:0] Dividend = QUOT_W'(DIVIDEND);

  div_state_e           state_q, state_d;
  logic [StepW-1:0]     step_q, step_d;
  logic [DIVISOR_W-1:0] rem_q, rem_d;
  logic [DIVISOR_W-1:0] divisor_q, divisor_d;
  logic [QUOT_W-1:0]    quot_q, quot_d;
  logic                 done_q, done_d;

  logic [DIVISOR_W:0]   trial;
  logic [DIVISOR_W:0]   diff;
  logic                 ge;

  // one restoring step: bring down a dividend bit, try the subtract
  assign trial = {rem_q, Dividend[step_q]};
  assign ge    = trial >= {1'b0, divisor_q};
  assign diff  = trial - {1'b0, divisor_q};

  always_comb begin
    state_d   = state_q;
    step_d    = step_q;
    rem_d     = rem_q;
    divisor_d = divisor_q;
    quot_d    = quot_q;
    done_d    = 1'b0;
    unique case (state_q)
      D_IDLE: begin
        if (req_i.start) begin
          divisor_d = req_i.divisor;
          rem_d     = '0;
          quot_d    = '0;
          step_d    = StepW'(QUOT_W - 1);
          state_d   = D_RUN;
        end
      end
      D_RUN: begin
        rem_d  = ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
        quot_d = {quot_q[QUOT_W-2:0], ge};
        if (step_q == '0) begin
          done_d  = 1'b1;
          state_d = D_IDLE;
        end else begin
          step_d = step_q - StepW'(1);
        end
      end
      default: state_d = D_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q    <= step_d;
    rem_q     <= rem_d;
    divisor_q <= divisor_d;
    quot_q    <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

`ifndef SYNTH
  a_start_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> state_q == D_IDLE)
    else $error("divider started while busy");
  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> state_q == D_IDLE)
    else $error("divider done while still running");
  a_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == D_RUN |-> divisor_q != '0)
    else $error("divider running on zero divisor");
`endif

endmodule

// File: src/mtcv_stack.sv
module mtcv_stack #(
  parameter int unsigned STACK_DEPTH = mtcv_pkg::STACK_DEPTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  mtcv_pkg::stack_req_t               req_i,
  output logic                               done_o,
  output logic [$clog2(STACK_DEPTH+1)-1:0]   count_o,
  output logic [mtcv_pkg::NOTE_W-1:0]        top_o
);
  import mtcv_pkg::*;

  localparam int unsigned CntW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned IdxW = $clog2(STACK_DEPTH);

  stack_state_e      state_q, state_d;
  logic [NOTE_W-1:0] notes_q [STACK_DEPTH];
  logic [NOTE_W-1:0] notes_d [STACK_DEPTH];
  logic [CntW-1:0]   count_q, count_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic [NOTE_W-1:0] key_q, key_d;
  logic              done_q, done_d;
  logic [CntW-1:0]   push_top;

  // newest at index 0; a full stack loses its oldest entry on push
  assign push_top = (count_q >= CntW'(STACK_DEPTH)) ? CntW'(STACK_DEPTH - 1) : count_q;

  always_comb begin
    state_d = state_q;
    notes_d = notes_q;
    count_d = count_q;
    idx_d   = idx_q;
    key_d   = key_q;
    done_d  = 1'b0;
    unique case (state_q)
      K_IDLE: begin
        if (req_i.start) begin
          if (req_i.pop) begin
            if (count_q == '0) begin
              done_d = 1'b1;
            end else begin
              key_d   = req_i.note;
              idx_d   = IdxW'(count_q - CntW'(1));
              state_d = K_SEARCH;
            end
          end else begin
            for (int i = 1; i < STACK_DEPTH; i++) begin
              if (CntW'(i) <= push_top) notes_d[i] = notes_q[i-1];
            end
            notes_d[0] = req_i.note;
            if (count_q < CntW'(STACK_DEPTH)) count_d = count_q + CntW'(1);
            done_d = 1'b1;
          end
        end
      end
      K_SEARCH: begin
        // oldest first, one compare a cycle
        if (notes_q[idx_q] == key_q) begin
          for (int i = 0; i < STACK_DEPTH - 1; i++) begin
            if (CntW'(i) >= CntW'(idx_q) && CntW'(i + 1) < count_q) begin
              notes_d[i] = notes_q[i+1];
            end
          end
          count_d = count_q - CntW'(1);
          done_d  = 1'b1;
          state_d = K_IDLE;
        end else if (idx_q == '0) begin
          done_d  = 1'b1;
          state_d = K_IDLE;
        end else begin
          idx_d = idx_q - IdxW'(1);
        end
      end
      default: state_d = K_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= K_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
      for (int i = 0; i < STACK_DEPTH; i++) notes_q[i] <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
      notes_q <= notes_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    key_q <= key_d;
  end

  assign done_o  = done_q;
  assign count_o = count_q;
  assign top_o   = notes_q[0];

`ifndef SYNTH
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(STACK_DEPTH))
    else $error("note count beyond stack depth");
  a_idx_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == K_SEARCH |-> CntW'(idx_q) < count_q)
    else $error("search index past held notes");
  a_start_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> state_q == K_IDLE)
    else $error("stack request while searching");
`endif

endmodule

// File: src/midi_to_cv_note_stack_top.sv
// MIDI to CV converter, last-note priority. One result item per MIDI byte.
// Accepted byte to result valid: a byte with no action goes straight to the result;
// a note on or note off goes through the stack (a note off searches it one entry a
// cycle); a control change above the off band runs the 11-step restoring divider.
// Next byte accepted the cycle after the result is loaded; one byte is in work at a time.
// Reset (async, active low) clears the stack and parser; glide PWM 1023, pitch 511.
module midi_to_cv_note_stack_top #(
  parameter int unsigned STACK_DEPTH = mtcv_pkg::STACK_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [7:0]                     midi_byte_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           gate_o,
  output logic [6:0]                     note_code_o,
  output logic [1:0]                     glide_select_o,
  output logic [mtcv_pkg::PWM_W-1:0]     pitch_pwm_o,
  output logic [mtcv_pkg::PWM_W-1:0]     glide_pwm_o
);
  import mtcv_pkg::*;

  localparam int unsigned CntW = $clog2(STACK_DEPTH + 1);

  top_state_e        state_q, state_d;
  cmd_e              rtype_q, rtype_d;      // running status
  logic [1:0]        pos_q, pos_d;          // byte position in message
  logic [7:0]        first_q, first_d;      // first data byte
  logic [1:0]        range_q, range_d;
  logic [1:0]        gsel_q, gsel_d;
  logic [6:0]        ncode_q, ncode_d;
  logic [PWM_W-1:0]  pitch_q, pitch_d;
  logic [PWM_W-1:0]  gpwm_q, gpwm_d;
  stack_req_t        stk_req_q, stk_req_d;
  div_req_t          div_req_q, div_req_d;
  logic              out_valid_q, out_valid_d;
  logic              load_out;

  // shared units
  logic              stk_done;
  logic [CntW-1:0]   stk_count;
  logic [NOTE_W-1:0] stk_top;
  logic              div_done;
  logic [QUOT_W-1:0] div_quot;

  // byte decode
  logic              is_status;
  cmd_e              status_cmd;
  cmd_e              rtype_eff;
  logic [1:0]        pos_eff;
  logic [NOTE_W-1:0] top_sub;
  logic [QUOT_W-1:0] quot_m1;

  assign is_status = midi_byte_i[7];
  assign top_sub   = stk_top - NOTE_OFFSET;
  assign quot_m1   = div_quot - QUOT_W'(1);

  always_comb begin
    unique case (midi_byte_i)
      ST_NOTE_ON:  status_cmd = CMD_NOTE_ON;
      ST_NOTE_OFF: status_cmd = CMD_NOTE_OFF;
      ST_PITCH:    status_cmd = CMD_PITCH;
      ST_CTRL:     status_cmd = CMD_CTRL;
      default:     status_cmd = CMD_NONE; // other channels, other message types, system messages
    endcase
  end

  assign rtype_eff = is_status ? status_cmd : rtype_q;
  assign pos_eff   = is_status ? 2'd0 : pos_q;

  always_comb begin
    state_d     = state_q;
    rtype_d     = rtype_q;
    pos_d       = pos_q;
    first_d     = first_q;
    range_d     = range_q;
    gsel_d      = gsel_q;
    ncode_d     = ncode_q;
    pitch_d     = pitch_q;
    gpwm_d      = gpwm_q;
    stk_req_d   = stk_req_q;
    stk_req_d.start = 1'b0;
    div_req_d   = div_req_q;
    div_req_d.start = 1'b0;
    load_out    = 1'b0;

    unique case (state_q)
      T_IDLE: begin
        if (in_valid_i) begin
          rtype_d = rtype_eff;
          // position runs 0,1,2,1,2,... so running status reuses the command
          pos_d   = (pos_eff == 2'd2) ? 2'd1 : pos_eff + 2'd1;
          if (rtype_eff != CMD_NONE && pos_eff == 2'd1) first_d = midi_byte_i;
          state_d = T_DONE;
          if (pos_eff == 2'd2) begin
            case (rtype_eff) inside
              CMD_NOTE_ON, CMD_NOTE_OFF: begin
                // velocity zero on a note on counts as note off
                stk_req_d.start = 1'b1;
                stk_req_d.pop   = (midi_byte_i == '0) || (rtype_eff == CMD_NOTE_OFF);
                stk_req_d.note  = first_q;
                state_d         = T_STACK;
              end
              CMD_PITCH: begin
                pitch_d = {midi_byte_i[6:0], 3'b000};
              end
              CMD_CTRL: begin
                // controller number not checked; value picks band and rate
                if (midi_byte_i <= GLIDE_OFF_MAX) begin
                  range_d = RANGE_OFF;
                  gpwm_d  = PWM_FULL;
                end else begin
                  div_req_d.start = 1'b1;
                  state_d         = T_DIV;
                  if (midi_byte_i < GLIDE_R1_LIM) begin
                    range_d           = RANGE_R1;
                    div_req_d.divisor = midi_byte_i - GLIDE_R1_SUB;
                  end else if (midi_byte_i <= GLIDE_R2_MAX) begin
                    range_d           = RANGE_R2;
                    div_req_d.divisor = midi_byte_i - GLIDE_R2_SUB;
                  end else begin
                    range_d           = RANGE_R3;
                    div_req_d.divisor = midi_byte_i - GLIDE_R3_SUB;
                  end
                end
              end
              default: ;
            endcase
          end
        end
      end
      T_STACK: begin
        if (stk_done) begin
          if (stk_req_q.pop) begin
            if (stk_count == '0) gsel_d = '0;
          end else if (stk_count > CntW'(1)) begin
            gsel_d = range_q;
          end
          ncode_d = top_sub[6:0];
          state_d = T_DONE;
        end
      end
      T_DIV: begin
        if (div_done) begin
          gpwm_d  = quot_m1[PWM_W-1:0];
          state_d = T_DONE;
        end
      end
      T_DONE: begin
        // output register frees up as soon as the old item is taken
        if (!out_valid_q || out_ready_i) begin
          load_out = 1'b1;
          state_d  = T_IDLE;
        end
      end
      default: state_d = T_IDLE;
    endcase
  end

  always_comb begin
    if (load_out) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
    else out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_IDLE;
      rtype_q     <= CMD_NONE;
      pos_q       <= 2'd0;
      first_q     <= '0;
      range_q     <= RANGE_OFF;
      gsel_q      <= GLIDE_SEL_RESET;
      ncode_q     <= '0;
      pitch_q     <= PITCH_RESET;
      gpwm_q      <= PWM_FULL;
      stk_req_q   <= '0;
      div_req_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rtype_q     <= rtype_d;
      pos_q       <= pos_d;
      first_q     <= first_d;
      range_q     <= range_d;
      gsel_q      <= gsel_d;
      ncode_q     <= ncode_d;
      pitch_q     <= pitch_d;
      gpwm_q      <= gpwm_d;
      stk_req_q   <= stk_req_d;
      div_req_q   <= div_req_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload, held while waiting to be taken
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      gate_o         <= (stk_count != '0);
      note_code_o    <= ncode_q;
      glide_select_o <= gsel_q;
      pitch_pwm_o    <= pitch_q;
      glide_pwm_o    <= gpwm_q;
    end
  end

  assign in_ready_o  = (state_q == T_IDLE);
  assign out_valid_o = out_valid_q;

  mtcv_stack #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (stk_req_q),
    .done_o  (stk_done),
    .count_o (stk_count),
    .top_o   (stk_top)
  );

  mtcv_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req_q),
    .done_o (div_done),
    .quot_o (div_quot)
  );

`ifndef SYNTH
  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second item taken while one is in work");
  a_stack_done_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    stk_done |-> state_q == T_STACK)
    else $error("stack finished outside its wait state");
  a_div_done_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == T_DIV)
    else $error("divider finished outside its wait state");
`endif

endmodule
